/* hw/rtl/rfas_pkg.sv */
// Shared types and constants of the register file add and sort unit.
// Used by rfas_cell, rfas_seq and register_file_add_sort_unit.
package rfas_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned DataW    = 32;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned KindW    = 2;
  localparam int unsigned RoundW   = (NumRegs > 2) ? $clog2(NumRegs) : 1;

  typedef enum logic [KindW-1:0] {
    KIND_SORT = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_ADDI = 2'd2,
    KIND_READ = 2'd3
  } kind_e;

  // What a cell does in the current cycle of a sort.
  typedef enum logic [1:0] {
    ROLE_HOLD = 2'd0,
    ROLE_LOW  = 2'd1,
    ROLE_HIGH = 2'd2
  } role_e;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_SORT = 2'd1,
    SEQ_DONE = 2'd2
  } seq_state_e;

  typedef struct packed {
    role_e role;
    logic  wr_en;
  } cell_cmd_t;

  typedef struct packed {
    logic sort_en;
    logic odd_round;
    logic busy;
    logic done;
  } seq_status_t;

endpackage

/* hw/rtl/rfas_cell.sv */
// One register of the chain: holds a value and compare-exchanges it with a neighbor.
// Depends on rfas_pkg.
module rfas_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rfas_pkg::cell_cmd_t            cmd_i,
  input  logic [rfas_pkg::DataW-1:0]     wr_data_i,
  input  logic [rfas_pkg::DataW-1:0]     left_i,
  input  logic [rfas_pkg::DataW-1:0]     right_i,
  output logic [rfas_pkg::DataW-1:0]     value_o
);

  logic [rfas_pkg::DataW-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (cmd_i.wr_en) begin
      value_d = wr_data_i;
    end else begin
      case (cmd_i.role)
        // The lower cell of a pair keeps the minimum, the upper one the maximum.
        rfas_pkg::ROLE_LOW:  value_d = (right_i < value_q) ? right_i : value_q;
        rfas_pkg::ROLE_HIGH: value_d = (left_i > value_q) ? left_i : value_q;
        default:             value_d = value_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

/* hw/rtl/rfas_seq.sv */
// Sort sequencer: counts the compare-exchange rounds and flags the end of a sort.
// Depends on rfas_pkg.
module rfas_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  out_free_i,
  output rfas_pkg::seq_status_t status_o
);

  rfas_pkg::seq_state_e             state_q, state_d;
  logic [rfas_pkg::RoundW-1:0]      round_q, round_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfas_pkg::SEQ_IDLE;
      round_q <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    round_d            = round_q;
    status_o.sort_en   = 1'b0;
    status_o.odd_round = round_q[0];
    status_o.busy      = 1'b0;
    status_o.done      = 1'b0;
    case (state_q)
      rfas_pkg::SEQ_IDLE: begin
        round_d = '0;
        if (start_i) begin
          state_d = rfas_pkg::SEQ_SORT;
        end
      end
      rfas_pkg::SEQ_SORT: begin
        status_o.sort_en = 1'b1;
        status_o.busy    = 1'b1;
        if (round_q == rfas_pkg::RoundW'(rfas_pkg::NumRegs - 1)) begin
          round_d = '0;
          state_d = rfas_pkg::SEQ_DONE;
        end else begin
          round_d = round_q + 1'b1;
        end
      end
      rfas_pkg::SEQ_DONE: begin
        status_o.busy = 1'b1;
        // The zero result of a sort goes out once the output register is free.
        if (out_free_i) begin
          status_o.done = 1'b1;
          state_d       = rfas_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_d = rfas_pkg::SEQ_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/register_file_add_sort_unit.sv */
// Top level of the register file add and sort unit.
// Depends on rfas_pkg, rfas_cell and rfas_seq.
//
// Eight 32-bit registers, cleared by reset, held in a row of cells. Each input
// beat carries one instruction (sort, add, add immediate or read) and yields
// exactly one output beat with result_value: the sum written, the value read,
// or zero for a sort. Both channels use valid and stall; a beat moves at a
// clock edge with valid high and stall low.
// Add, add immediate and read execute at the accepting edge and their result
// is loaded into the output register at that edge. A sort runs one odd-even
// transposition round per cycle across the cells, NumRegs rounds, then loads
// its zero result once the output register is free. Throughput is one beat
// per cycle for add and read while the receiver takes results; a sort holds
// off the input through its rounds and until its zero result is loaded.
// While the output register holds a result that the receiver stalls, or while
// a sort runs, in_stall_o is high. Reset clears the eight registers, the
// sequencer and the output valid; the output value register is not reset.
module register_file_add_sort_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rfas_pkg::KindW-1:0]        kind_i,
  input  logic [rfas_pkg::RegIdxW-1:0]      dest_reg_i,
  input  logic [rfas_pkg::RegIdxW-1:0]      src_a_reg_i,
  input  logic [rfas_pkg::RegIdxW-1:0]      src_b_reg_i,
  input  logic [rfas_pkg::DataW-1:0]        immediate_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rfas_pkg::DataW-1:0]        result_value_o
);

  localparam int unsigned N = rfas_pkg::NumRegs;

  logic [rfas_pkg::DataW-1:0] reg_val [N];
  rfas_pkg::cell_cmd_t        cell_cmd [N];
  rfas_pkg::seq_status_t      seq_status;

  logic                       out_valid_q, out_valid_d;
  logic [rfas_pkg::DataW-1:0] out_value_q, out_value_d;
  logic                       out_free;
  logic                       accept;
  logic                       is_sort;
  logic                       wr_fire;
  logic [rfas_pkg::DataW-1:0] src_a_val, src_b_val, exec_val;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = seq_status.busy || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_sort    = (kind_i == rfas_pkg::KIND_SORT);
  assign wr_fire    = accept && ((kind_i == rfas_pkg::KIND_ADD) ||
                                 (kind_i == rfas_pkg::KIND_ADDI));

  // Source reads; an index past the last register reads as zero.
  always_comb begin
    src_a_val = '0;
    src_b_val = '0;
    for (int i = 0; i < N; i++) begin
      if (int'(src_a_reg_i) == i) src_a_val = reg_val[i];
      if (int'(src_b_reg_i) == i) src_b_val = reg_val[i];
    end
  end

  always_comb begin
    case (kind_i)
      rfas_pkg::KIND_ADD:  exec_val = src_a_val + src_b_val;
      rfas_pkg::KIND_ADDI: exec_val = src_a_val + immediate_i;
      rfas_pkg::KIND_READ: exec_val = src_a_val;
      default:             exec_val = '0;
    endcase
  end

  // Cell commands: writes land on the destination, sort rounds pair cells
  // starting at index zero on even rounds and index one on odd rounds.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      cell_cmd[i].wr_en = wr_fire && (int'(dest_reg_i) == i);
      cell_cmd[i].role  = rfas_pkg::ROLE_HOLD;
      if (seq_status.sort_en) begin
        if ((i[0] == seq_status.odd_round) && (i + 1 < N)) begin
          cell_cmd[i].role = rfas_pkg::ROLE_LOW;
        end else if ((i >= 1) && (i[0] != seq_status.odd_round)) begin
          cell_cmd[i].role = rfas_pkg::ROLE_HIGH;
        end
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [rfas_pkg::DataW-1:0] left_val, right_val;
    if (g == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_left
      assign left_val = reg_val[g-1];
    end
    if (g == N - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_right
      assign right_val = reg_val[g+1];
    end
    rfas_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cell_cmd[g]),
      .wr_data_i (exec_val),
      .left_i    (left_val),
      .right_i   (right_val),
      .value_o   (reg_val[g])
    );
  end

  rfas_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && is_sort),
    .out_free_i (out_free),
    .status_o   (seq_status)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    if (accept && !is_sort) begin
      out_valid_d = 1'b1;
      out_value_d = exec_val;
    end else if (seq_status.done) begin
      out_valid_d = 1'b1;
      out_value_d = '0;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;

endmodule
